// ----- design/trd_pkg.sv -----
// Shared types and constants for the touch report event decoder.
// Stands alone: every other design file refers to it by scoped names.
package trd_pkg;

    // Finger slots that keep an active bit and a last position
    localparam int TRACKED_FINGERS = 5;
    localparam int FIDX_W = (TRACKED_FINGERS > 1) ? $clog2(TRACKED_FINGERS) : 1;

    // Largest slot count the controller can report
    localparam logic [4:0] MAX_POINTS_LIMIT = 5'd16;
    localparam logic [4:0] MAX_POINTS_RESET = 5'd5;
    localparam logic [7:0] FIRST_ID_RESET   = 8'h00;
    // Touch reports start two ids above the first instance id
    localparam logic [9:0] TOUCH_ID_OFFSET  = 10'd2;

    // Event codes in the low nibble of the status byte
    localparam logic [3:0] EV_NONE = 4'h0;
    localparam logic [3:0] EV_MOVE = 4'h1;
    localparam logic [3:0] EV_DOWN = 4'h4;
    localparam logic [3:0] EV_UP   = 4'h5;

    // Result kinds
    localparam logic [2:0] KIND_REL_X = 3'd0;
    localparam logic [2:0] KIND_REL_Y = 3'd1;
    localparam logic [2:0] KIND_SLOT  = 3'd2;
    localparam logic [2:0] KIND_ABS_X = 3'd3;
    localparam logic [2:0] KIND_ABS_Y = 3'd4;
    localparam logic [2:0] KIND_KEY   = 3'd5;

    // Input mode
    localparam logic MODE_TOUCH = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Register address decode (word index from paddr bit 2)
    localparam logic REG_FIRST_ID   = 1'b0;
    localparam logic REG_MAX_POINTS = 1'b1;

    // Result positions within one item's list, in output order
    localparam int POS_REL_X   = 0;
    localparam int POS_REL_Y   = 1;
    localparam int POS_KEY_SYN = 2;
    localparam int POS_SLOT    = 3;
    localparam int POS_ABS_X   = 4;
    localparam int POS_ABS_Y   = 5;
    localparam int POS_KEY     = 6;
    localparam int NUM_POS     = 7;

    typedef struct packed {
        logic        mode;
        logic [7:0]  msg_id;
        logic [7:0]  status_byte;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } trd_item_t;

    // Result list of one item: presence mask and the values behind it
    typedef struct packed {
        logic [NUM_POS-1:0] mask;
        logic [15:0]        rel_x;
        logic [15:0]        rel_y;
        logic               flush_key;
        logic [3:0]         slot;
        logic [15:0]        abs_x;
        logic [15:0]        abs_y;
        logic               key;
    } trd_events_t;

endpackage

// ----- design/touch_report_event_decoder_core.sv -----
// Top level of the touch report event decoder: input register, register port,
// decoder and result serialiser. Depends on trd_pkg, trd_decode and trd_serial.
//
//  channel   | direction | handshake                 | contents
//  ----------+-----------+---------------------------+-------------------------------------
//  s_axis    | in        | tvalid / tready           | one touch message or batch flush
//  m_axis    | out       | tvalid / tready, tlast    | one input event per transfer
//  apb       | in        | psel, penable, pready     | first id (0x0), max_points (0x4)
//
// A message request waits in the input register, is decoded in the cycle it moves into
// the result list, and then its results leave at one per cycle while m_axis_tready is
// high. An item yields at most seven results, and the serialiser is what sets the
// sustained rate. The next message is taken while the final result of the previous one
// is still waiting, and is decoded as that result is taken. Reset clears the finger
// tracking, the batch state, both registers to their defaults and all valid flags.
// Back-pressure on the output holds the current result steady and, once the input
// register is full, lowers s_axis_tready.
module touch_report_event_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [7:0] msg_id, [15:8] status_byte,
                                        // [31:16] pos_x, [47:32] pos_y
    input  logic [0:0]  s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] event_value, [23:17] zero
    output logic [3:0]  m_axis_tuser,   // [2:0] event_kind, [3] sync
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers. Only address bit 2 selects the register.
    logic [7:0]           first_id_reg;
    logic [4:0]           max_points_reg;
    logic                 cfg_write;

    // Input register holding one accepted request
    trd_pkg::trd_item_t   item_reg;
    logic                 item_valid_reg;
    logic                 item_valid_next;

    trd_pkg::trd_events_t evt;
    logic                 can_load;
    logic                 load;
    logic                 accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == trd_pkg::REG_MAX_POINTS) ? {27'h0, max_points_reg}
                                                             : {24'h0, first_id_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg   <= trd_pkg::FIRST_ID_RESET;
            max_points_reg <= trd_pkg::MAX_POINTS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == trd_pkg::REG_FIRST_ID)
                first_id_reg <= pwdata[7:0];
            else
                max_points_reg <= pwdata[4:0];
        end
    end

    // The held request moves on into the decoder whenever the result list has room,
    // so the input register frees up in that same cycle.
    assign load          = item_valid_reg && can_load;
    assign s_axis_tready = !item_valid_reg || load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (load)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode        <= s_axis_tuser[0];
            item_reg.msg_id      <= s_axis_tdata[7:0];
            item_reg.status_byte <= s_axis_tdata[15:8];
            item_reg.pos_x       <= s_axis_tdata[31:16];
            item_reg.pos_y       <= s_axis_tdata[47:32];
        end
    end

    trd_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .item       (item_reg),
        .first_id   (first_id_reg),
        .max_points (max_points_reg),
        .evt        (evt)
    );

    trd_serial u_serial
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .evt           (evt),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Relative deltas always come as a pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (evt.mask[trd_pkg::POS_REL_X] == evt.mask[trd_pkg::POS_REL_Y]))
        else $error("relative X and Y deltas not paired");

    // A batch flush yields at most the single synchronising touch key.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (item_reg.mode == trd_pkg::MODE_FLUSH)) |=>
        ((m_axis_tvalid == 1'b0) || (m_axis_tlast && m_axis_tuser[3] &&
                                     (m_axis_tuser[2:0] == trd_pkg::KIND_KEY))))
        else $error("flush produced something other than one synced key");

    // A new list is only taken in once the previous one has been fully sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && m_axis_tvalid) |-> (m_axis_tready && m_axis_tlast))
        else $error("result list overwritten before its last entry left");

    // A request waiting in the input register is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !load) |-> !s_axis_tready)
        else $error("input register accepted while still occupied");

endmodule

// ----- design/trd_decode.sv -----
// Decodes one touch message against the finger tracking state and builds its result list.
// Depends on trd_pkg; holds the per-finger state and the batch state.
module trd_decode
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  trd_pkg::trd_item_t   item,
    input  logic [7:0]           first_id,
    input  logic [4:0]           max_points,
    output trd_pkg::trd_events_t evt
);

    logic                      active_reg [trd_pkg::TRACKED_FINGERS];
    logic [15:0]               prev_x_reg [trd_pkg::TRACKED_FINGERS];
    logic [15:0]               prev_y_reg [trd_pkg::TRACKED_FINGERS];
    logic [15:0]               pending_reg;
    logic [15:0]               pending_next;
    logic                      last_touch_reg;
    logic                      last_touch_next;

    logic [4:0]                pts;
    logic [9:0]                lo;
    logic [9:0]                hi;
    logic [9:0]                rid;
    logic [9:0]                diff;
    logic                      in_range;
    logic [3:0]                idx;
    logic                      tracked;
    logic [trd_pkg::FIDX_W-1:0] fi;
    logic [3:0]                ev;
    logic                      known;
    logic                      move_hit;
    logic [15:0]               dx;
    logic [15:0]               dy;
    logic                      moved;
    logic                      touching;

    always_comb
    begin
        pts      = (max_points > trd_pkg::MAX_POINTS_LIMIT) ? trd_pkg::MAX_POINTS_LIMIT
                                                            : max_points;
        lo       = {2'b00, first_id} + trd_pkg::TOUCH_ID_OFFSET;
        hi       = lo + {5'b00000, pts};
        rid      = {2'b00, item.msg_id};
        in_range = (rid >= lo) && (rid < hi);
        diff     = rid - lo;
        idx      = diff[3:0];
        tracked  = ({1'b0, idx} < 5'(trd_pkg::TRACKED_FINGERS));
        fi       = tracked ? idx[trd_pkg::FIDX_W-1:0] : '0;
        ev       = item.status_byte[3:0];
        known    = (ev == trd_pkg::EV_NONE) || (ev == trd_pkg::EV_MOVE) ||
                   (ev == trd_pkg::EV_DOWN) || (ev == trd_pkg::EV_UP);
        move_hit = tracked && (ev == trd_pkg::EV_MOVE) && active_reg[fi];
        dx       = item.pos_x - prev_x_reg[fi];
        dy       = item.pos_y - prev_y_reg[fi];
        moved    = (dx != 16'h0000) || (dy != 16'h0000);
        touching = (ev != trd_pkg::EV_UP);

        evt           = '0;
        evt.rel_x     = dx;
        evt.rel_y     = dy;
        evt.flush_key = last_touch_reg;
        evt.slot      = idx;
        evt.abs_x     = item.pos_x;
        evt.abs_y     = item.pos_y;
        evt.key       = touching;

        pending_next    = pending_reg;
        last_touch_next = last_touch_reg;

        if (item.mode == trd_pkg::MODE_FLUSH)
        begin
            evt.mask[trd_pkg::POS_KEY_SYN] = (pending_reg != 16'h0000);
            pending_next    = 16'h0000;
            last_touch_next = 1'b0;
        end
        else if (in_range)
        begin
            evt.mask[trd_pkg::POS_REL_X] = move_hit && moved;
            evt.mask[trd_pkg::POS_REL_Y] = move_hit && moved;
            if (known)
            begin
                // A finger seen twice in one batch closes the previous frame first
                evt.mask[trd_pkg::POS_KEY_SYN] = pending_reg[idx];
                evt.mask[trd_pkg::POS_SLOT]    = 1'b1;
                evt.mask[trd_pkg::POS_ABS_X]   = 1'b1;
                evt.mask[trd_pkg::POS_ABS_Y]   = 1'b1;
                evt.mask[trd_pkg::POS_KEY]     = 1'b1;
                pending_next    = (pending_reg[idx] ? 16'h0000 : pending_reg) |
                                  (16'h0001 << idx);
                last_touch_next = touching;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 16'h0000;
            last_touch_reg <= 1'b0;
            for (int i = 0; i < trd_pkg::TRACKED_FINGERS; i++)
            begin
                active_reg[i] <= 1'b0;
                prev_x_reg[i] <= 16'h0000;
                prev_y_reg[i] <= 16'h0000;
            end
        end
        else if (load)
        begin
            pending_reg    <= pending_next;
            last_touch_reg <= last_touch_next;
            if ((item.mode == trd_pkg::MODE_TOUCH) && in_range && tracked)
            begin
                if (ev == trd_pkg::EV_DOWN)
                begin
                    active_reg[fi] <= 1'b1;
                    prev_x_reg[fi] <= item.pos_x;
                    prev_y_reg[fi] <= item.pos_y;
                end
                else if (move_hit)
                begin
                    prev_x_reg[fi] <= item.pos_x;
                    prev_y_reg[fi] <= item.pos_y;
                end
                else if (ev == trd_pkg::EV_UP)
                begin
                    active_reg[fi] <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- design/trd_serial.sv -----
// Holds one item's result list and sends its entries out one per cycle while m_axis_tready is high.
// Depends on trd_pkg for the result list type and the kind codes.
module trd_serial
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  trd_pkg::trd_events_t evt,
    output logic                 can_load,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [16:0] event_value, [23:17] zero
    output logic [3:0]           m_axis_tuser,   // [2:0] event_kind, [3] sync
    output logic                 m_axis_tlast
);

    trd_pkg::trd_events_t              evt_reg;
    logic [trd_pkg::NUM_POS-1:0]       mask_reg;
    logic [trd_pkg::NUM_POS-1:0]       mask_next;
    logic [trd_pkg::NUM_POS-1:0]       cur;
    logic [trd_pkg::NUM_POS-1:0]       rest;
    logic [16:0]                       value;
    logic [2:0]                        kind;
    logic                              sync;
    logic                              take;

    always_comb
    begin
        // Lowest pending entry goes first
        cur  = mask_reg & (~mask_reg + 7'd1);
        rest = mask_reg & ~cur;
        take = m_axis_tvalid && m_axis_tready;

        value = 17'd0;
        kind  = trd_pkg::KIND_KEY;
        sync  = 1'b0;
        case (cur)
            7'b0000001:
            begin
                value = {evt_reg.rel_x[15], evt_reg.rel_x};
                kind  = trd_pkg::KIND_REL_X;
            end
            7'b0000010:
            begin
                value = {evt_reg.rel_y[15], evt_reg.rel_y};
                kind  = trd_pkg::KIND_REL_Y;
                sync  = 1'b1;
            end
            7'b0000100:
            begin
                value = {16'h0000, evt_reg.flush_key};
                kind  = trd_pkg::KIND_KEY;
                sync  = 1'b1;
            end
            7'b0001000:
            begin
                value = {13'h0000, evt_reg.slot};
                kind  = trd_pkg::KIND_SLOT;
            end
            7'b0010000:
            begin
                value = {1'b0, evt_reg.abs_x};
                kind  = trd_pkg::KIND_ABS_X;
            end
            7'b0100000:
            begin
                value = {1'b0, evt_reg.abs_y};
                kind  = trd_pkg::KIND_ABS_Y;
            end
            7'b1000000:
            begin
                value = {16'h0000, evt_reg.key};
                kind  = trd_pkg::KIND_KEY;
            end
            default:
            begin
                value = 17'd0;
                kind  = trd_pkg::KIND_KEY;
            end
        endcase

        m_axis_tvalid = (mask_reg != '0);
        m_axis_tdata  = {7'h00, value};
        m_axis_tuser  = {sync, kind};
        m_axis_tlast  = (rest == '0);

        // Room for a new list once the old one is empty or its final entry leaves
        can_load = (mask_reg == '0) || (take && (rest == '0));

        mask_next = mask_reg;
        if (load)
            mask_next = evt.mask;
        else if (take)
            mask_next = rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            evt_reg <= evt;
    end

endmodule
